### hdl/swm_pkg.sv
// ----------------------------------------------------------------------------
// swm_pkg
// Shared constants and controller/datapath command and status types for the
// sliding window maximum block.
// ----------------------------------------------------------------------------
package swm_pkg;

   localparam int SAMPLE_WIDTH_DEF = 32;
   localparam int WINDOW_MAX_DEF   = 64;
   localparam int WSIZE_W          = 7;
   localparam int POS_W            = 7;

   typedef struct packed {
      logic accept;
      logic rd_tail;
      logic rd_head;
      logic pop_tail;
      logic pop_head;
      logic append;
      logic load_out;
   } swm_cmd_type;

   typedef struct packed {
      logic count_zero;
      logic tail_less;
      logic head_expired;
      logic emit;
      logic out_busy;
   } swm_status_type;

endpackage

### hdl/swm_channels.sv
// ----------------------------------------------------------------------------
// swm channels
// Valid/ready channel interfaces for samples, results and the window size.
// ----------------------------------------------------------------------------
interface swm_req_if #(
   parameter int SAMPLE_WIDTH = swm_pkg::SAMPLE_WIDTH_DEF
);
   logic                           valid;
   logic                           ready;
   logic signed [SAMPLE_WIDTH-1:0] sample;
   logic                           start_req;

   modport source (output valid, output sample, output start_req, input ready);
   modport sink   (input valid, input sample, input start_req, output ready);
endinterface

interface swm_rsp_if #(
   parameter int SAMPLE_WIDTH = swm_pkg::SAMPLE_WIDTH_DEF
);
   logic                           valid;
   logic                           ready;
   logic signed [SAMPLE_WIDTH-1:0] window_max;

   modport source (output valid, output window_max, input ready);
   modport sink   (input valid, input window_max, output ready);
endinterface

interface swm_csr_if;
   logic                         valid;
   logic                         ready;
   logic [swm_pkg::WSIZE_W-1:0]  window_size;

   modport source (output valid, output window_size, input ready);
   modport sink   (input valid, input window_size, output ready);
endinterface

### hdl/swm_datapath.sv
// ----------------------------------------------------------------------------
// swm_datapath
// Candidate memory, deque pointers, stream counters, window size register
// and the result register.
// ----------------------------------------------------------------------------
module swm_datapath #(
   parameter int SAMPLE_WIDTH = swm_pkg::SAMPLE_WIDTH_DEF,
   parameter int WINDOW_MAX   = swm_pkg::WINDOW_MAX_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  swm_pkg::swm_cmd_type                 cmd,
   output swm_pkg::swm_status_type              status,
   input  logic signed [SAMPLE_WIDTH-1:0]       req_sample,
   input  logic                                 req_start_req,
   input  logic                                 csr_valid,
   input  logic [swm_pkg::WSIZE_W-1:0]          csr_window_size,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [SAMPLE_WIDTH-1:0]       rsp_window_max
);
   import swm_pkg::*;

   localparam int PTR_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
   localparam int CNT_W = $clog2(WINDOW_MAX + 1);
   localparam int WCLAMP = (WINDOW_MAX < 127) ? WINDOW_MAX : 127;
   localparam logic [WSIZE_W-1:0] WCLAMP_V = WSIZE_W'(WCLAMP);
   localparam logic [PTR_W-1:0]   PTR_LAST = PTR_W'(WINDOW_MAX - 1);

   logic signed [SAMPLE_WIDTH-1:0] value_mem [WINDOW_MAX];
   logic [POS_W-1:0]               pos_mem   [WINDOW_MAX];

   logic signed [SAMPLE_WIDTH-1:0] sample_ff;
   logic signed [SAMPLE_WIDTH-1:0] rd_val_ff;
   logic [POS_W-1:0]               rd_pos_ff;
   logic signed [SAMPLE_WIDTH-1:0] out_ff, out_in;
   logic                           out_valid_ff, out_valid_in;
   logic [PTR_W-1:0]               head_ff, head_in;
   logic [PTR_W-1:0]               wr_ff, wr_in;
   logic [CNT_W-1:0]               count_ff, count_in;
   logic [POS_W-1:0]               pos_ff, pos_in;
   logic [WSIZE_W-1:0]             seen_ff, seen_in;
   logic [WSIZE_W-1:0]             wsize_ff, wsize_in;

   logic [WSIZE_W-1:0]             win;
   logic [WSIZE_W-1:0]             seen_next;
   logic [PTR_W-1:0]               tail_idx;
   logic [PTR_W-1:0]               rd_addr;
   logic [POS_W-1:0]               age;

   function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
      return (p == PTR_LAST) ? '0 : p + PTR_W'(1);
   endfunction

   function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] p);
      return (p == '0) ? PTR_LAST : p - PTR_W'(1);
   endfunction

   always_comb begin
      if (wsize_ff == '0) begin
         win = WSIZE_W'(1);
      end else if (wsize_ff > WCLAMP_V) begin
         win = WCLAMP_V;
      end else begin
         win = wsize_ff;
      end
   end

   assign seen_next = (seen_ff < win) ? seen_ff + WSIZE_W'(1) : seen_ff;
   assign tail_idx  = ptr_dec(wr_ff);
   assign rd_addr   = cmd.rd_tail ? tail_idx : head_ff;
   assign age       = pos_ff - rd_pos_ff;

   assign status.count_zero   = (count_ff == '0);
   assign status.tail_less    = (rd_val_ff < sample_ff);
   assign status.head_expired = (age >= win);
   assign status.emit         = (seen_next >= win);
   assign status.out_busy     = out_valid_ff && !rsp_ready;

   always_comb begin
      head_in      = head_ff;
      wr_in        = wr_ff;
      count_in     = count_ff;
      pos_in       = pos_ff;
      seen_in      = seen_ff;
      wsize_in     = wsize_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      if (csr_valid) begin
         wsize_in = csr_window_size;
      end
      if (cmd.accept && req_start_req) begin
         head_in  = '0;
         wr_in    = '0;
         count_in = '0;
         pos_in   = '0;
         seen_in  = '0;
      end
      if (cmd.pop_tail) begin
         wr_in    = tail_idx;
         count_in = count_ff - CNT_W'(1);
      end
      if (cmd.pop_head) begin
         head_in  = ptr_inc(head_ff);
         count_in = count_ff - CNT_W'(1);
      end
      if (cmd.append) begin
         wr_in    = ptr_inc(wr_ff);
         count_in = count_ff + CNT_W'(1);
         pos_in   = pos_ff + POS_W'(1);
         seen_in  = seen_next;
      end
      if (cmd.load_out) begin
         out_in       = (count_ff == '0) ? sample_ff : rd_val_ff;
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         wr_ff        <= '0;
         count_ff     <= '0;
         pos_ff       <= '0;
         seen_ff      <= '0;
         wsize_ff     <= WSIZE_W'(1);
         out_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         wr_ff        <= wr_in;
         count_ff     <= count_in;
         pos_ff       <= pos_in;
         seen_ff      <= seen_in;
         wsize_ff     <= wsize_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
      if (cmd.accept) begin
         sample_ff <= req_sample;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.append) begin
         value_mem[wr_ff] <= sample_ff;
         pos_mem[wr_ff]   <= pos_ff;
      end
      if (cmd.rd_tail || cmd.rd_head) begin
         rd_val_ff <= value_mem[rd_addr];
         rd_pos_ff <= pos_mem[rd_addr];
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_window_max = out_ff;

endmodule

### hdl/swm_controller.sv
// ----------------------------------------------------------------------------
// swm_controller
// Sequences one sample through tail drops, head expiry and the append.
// ----------------------------------------------------------------------------
module swm_controller (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  swm_pkg::swm_status_type  status,
   output swm_pkg::swm_cmd_type     cmd
);
   import swm_pkg::*;

   localparam logic [2:0] ST_IDLE     = 3'd0;
   localparam logic [2:0] ST_TAIL_RD  = 3'd1;
   localparam logic [2:0] ST_TAIL_CMP = 3'd2;
   localparam logic [2:0] ST_HEAD_RD  = 3'd3;
   localparam logic [2:0] ST_HEAD_CMP = 3'd4;
   localparam logic [2:0] ST_APPEND   = 3'd5;

   logic [2:0] state_ff, state_in;

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = ST_TAIL_RD;
            end
         end
         ST_TAIL_RD: begin
            if (status.count_zero) begin
               state_in = ST_HEAD_RD;
            end else begin
               cmd.rd_tail = 1'b1;
               state_in    = ST_TAIL_CMP;
            end
         end
         ST_TAIL_CMP: begin
            if (status.tail_less) begin
               cmd.pop_tail = 1'b1;
               state_in     = ST_TAIL_RD;
            end else begin
               state_in = ST_HEAD_RD;
            end
         end
         ST_HEAD_RD: begin
            if (status.count_zero) begin
               state_in = ST_APPEND;
            end else begin
               cmd.rd_head = 1'b1;
               state_in    = ST_HEAD_CMP;
            end
         end
         ST_HEAD_CMP: begin
            if (status.head_expired) begin
               cmd.pop_head = 1'b1;
               state_in     = ST_HEAD_RD;
            end else begin
               state_in = ST_APPEND;
            end
         end
         ST_APPEND: begin
            if (!(status.emit && status.out_busy)) begin
               cmd.append   = 1'b1;
               cmd.load_out = status.emit;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### hdl/sliding_window_maximum.sv
// ----------------------------------------------------------------------------
// sliding_window_maximum
// Sequence: an accepted sample reads and drops deque tail entries while
//   smaller, then head entries while expired, then is appended and any
//   result registered, through the single read port of the candidate memory.
// Samples: a new one is taken only once the last is appended; a waiting
//   result holds the append of the next sample that produces a result.
// Reset: synchronous; clears the deque, counters and result valid, window 1.
// ----------------------------------------------------------------------------
module sliding_window_maximum #(
   parameter int SAMPLE_WIDTH = swm_pkg::SAMPLE_WIDTH_DEF,
   parameter int WINDOW_MAX   = swm_pkg::WINDOW_MAX_DEF
) (
   input  logic       clock,
   input  logic       reset,
   swm_req_if.sink    req,
   swm_rsp_if.source  rsp,
   swm_csr_if.sink    csr
);
   import swm_pkg::*;

   swm_cmd_type    cmd;
   swm_status_type status;

   assign csr.ready = 1'b1;

   swm_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .status    (status),
      .cmd       (cmd)
   );

   swm_datapath #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH),
      .WINDOW_MAX   (WINDOW_MAX)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_sample      (req.sample),
      .req_start_req   (req.start_req),
      .csr_valid       (csr.valid),
      .csr_window_size (csr.window_size),
      .rsp_valid       (rsp.valid),
      .rsp_ready       (rsp.ready),
      .rsp_window_max  (rsp.window_max)
   );

endmodule

### hdl/swm_checker.sv
// ----------------------------------------------------------------------------
// swm_checker
// Port-level checks on the sliding window maximum block.
// ----------------------------------------------------------------------------
module swm_checker #(
   parameter int SAMPLE_WIDTH = swm_pkg::SAMPLE_WIDTH_DEF
) (
   input logic                    clock,
   input logic                    reset,
   input logic                    req_valid,
   input logic                    req_ready,
   input logic                    rsp_valid,
   input logic                    rsp_ready,
   input logic [SAMPLE_WIDTH-1:0] rsp_window_max,
   input logic                    csr_ready
);

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped before transaction");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_window_max))
      else $error("result changed while stalled");

   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("sample taken in consecutive cycles");

   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !$rose(rsp_valid))
      else $error("result appeared one cycle after a sample");

   assert property (@(posedge clock) disable iff (reset)
      csr_ready)
      else $error("window size port not ready");

endmodule

bind sliding_window_maximum swm_checker #(
   .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_swm_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req.valid),
   .req_ready      (req.ready),
   .rsp_valid      (rsp.valid),
   .rsp_ready      (rsp.ready),
   .rsp_window_max (rsp.window_max),
   .csr_ready      (csr.ready)
);
